// ===== rtl/mbrs_pkg.sv =====
// Package: shared constants, types and the CRC step for the Modbus register slave.
package mbrs_pkg;

	localparam int REG_COUNT_DEF = 10;
	localparam logic [7:0] FUNC_READ = 8'h03;
	localparam logic [7:0] FUNC_WRITE = 8'h06;
	localparam logic [15:0] READ_MAX = 16'd2;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// classified request handed from front to back
	typedef struct packed {
		logic        is_read;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic [7:0]  b4;
		logic [7:0]  b5;
		logic [7:0]  b6;
		logic [7:0]  b7;
		logic        two;
	} mbrs_cmd_t;

	// one byte of CRC-16/MODBUS, eight shift steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		c = crc ^ {8'h00, d};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else c = c >> 1;
		end
		return c;
	endfunction

endpackage

// ===== rtl/modbus_rtu_register_slave.sv =====
// Top level of the Modbus RTU holding-register slave (functions 03 and 06).
// Usage:
//  - in channel: one complete 8-byte request frame per item (in_valid/in_ready).
//  - out channel: response bytes in send order, resp_last on the final byte.
//  - cfg channel: writes slave_address (reset value 1); write only when idle.
// The front end checks address and CRC-16/MODBUS one byte per cycle and
// classifies the frame; a one-entry command register hands it to the back end.
// Front steps per frame: capture, six CRC bytes, evaluate, hand-off.
// The back end sends 7, 8 or 9 bytes at one per cycle while the receiver is
// ready, folding each byte ahead of the CRC into the response CRC; it takes
// no new command until the last byte of a response has been taken.
// Dropped frames (address, CRC, function or read range) give no output.
// A write to an address in range updates the register when its echo starts.
// Reset clears the register file and all control; no clearing pass.
// When the receiver stalls, the back end holds its byte and the front end
// holds its command, then stops taking frames.
module modbus_rtu_register_slave #(
	parameter int REG_COUNT = mbrs_pkg::REG_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] frame_address,
	input  logic [7:0] frame_function,
	input  logic [7:0] reg_addr_hi,
	input  logic [7:0] reg_addr_lo,
	input  logic [7:0] operand_hi,
	input  logic [7:0] operand_lo,
	input  logic [7:0] crc_byte_a,
	input  logic [7:0] crc_byte_b,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] resp_byte,
	output logic       resp_last
);
	import mbrs_pkg::*;

	logic [7:0] slave_q;
	logic       cmd_valid, cmd_ready;
	mbrs_cmd_t  cmd;

	assign cfg_ready = 1'b1;

	// slave address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) slave_q <= 8'd1;
		else if (cfg_valid) slave_q <= cfg_data;
	end

	mbrs_front #(.REG_COUNT(REG_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_bytes({frame_address, frame_function, reg_addr_hi, reg_addr_lo,
			operand_hi, operand_lo, crc_byte_a, crc_byte_b}),
		.slave_addr(slave_q), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	mbrs_back #(.REG_COUNT(REG_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .out_valid(out_valid), .out_ready(out_ready),
		.out_byte(resp_byte), .out_last(resp_last)
	);

	// a forwarded command always carries a supported function code
	a_cmd_func: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> (cmd.b1 == FUNC_READ || cmd.b1 == FUNC_WRITE))
		else $error("bad function forwarded");
	// a pending command holds while the back end is busy
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("command changed while stalled");
	// the front end takes no frame while a command waits
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> !in_ready)
		else $error("frame taken while command pending");
endmodule

// ===== rtl/mbrs_front.sv =====
// Front end: byte-serial CRC check and classification of request frames.
module mbrs_front #(
	parameter int REG_COUNT = mbrs_pkg::REG_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [63:0]         in_bytes,
	input  logic [7:0]          slave_addr,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output mbrs_pkg::mbrs_cmd_t cmd
);
	import mbrs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CRC  = 3'd1;
	localparam logic [2:0] ST_EVAL = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;

	logic [2:0]  state_q;
	logic [2:0]  idx_q;
	logic [63:0] frame_q;
	logic [15:0] crc_q;
	mbrs_cmd_t   cmd_q;

	logic [7:0]  cur_byte;
	logic [15:0] addr, opnd, crc_sum;
	logic [16:0] end_addr;
	logic        crc_ok, pass, rd_ok;

	assign cur_byte = frame_q[63 - 8*idx_q -: 8];
	assign addr = frame_q[47:32];
	assign opnd = frame_q[31:16];
	assign end_addr = {1'b0, addr} + {1'b0, opnd};
	assign crc_sum = crc_q;
	assign crc_ok = (frame_q[15:8] == crc_sum[7:0] && frame_q[7:0] == crc_sum[15:8]) ||
		(frame_q[15:8] == crc_sum[15:8] && frame_q[7:0] == crc_sum[7:0]);
	assign rd_ok = (opnd != 16'd0) && (opnd <= READ_MAX) && (end_addr <= 17'(REG_COUNT));
	assign pass = crc_ok && (frame_q[63:56] == slave_addr) &&
		((frame_q[55:48] == FUNC_WRITE) || (frame_q[55:48] == FUNC_READ && rd_ok));

	assign in_ready = (state_q == ST_IDLE);
	assign cmd_valid = (state_q == ST_OUT);
	assign cmd = cmd_q;

	// sequencer: one CRC byte per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= 3'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CRC;
						idx_q <= 3'd0;
					end
				end
				ST_CRC: begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd5) state_q <= ST_EVAL;
				end
				ST_EVAL: state_q <= pass ? ST_OUT : ST_IDLE;
				ST_OUT: if (cmd_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			frame_q <= in_bytes;
			crc_q <= CRC_INIT;
		end
		if (state_q == ST_CRC) crc_q <= crc_byte(crc_q, cur_byte);
		if (state_q == ST_EVAL) begin
			cmd_q.is_read <= (frame_q[55:48] == FUNC_READ);
			cmd_q.b0 <= frame_q[63:56];
			cmd_q.b1 <= frame_q[55:48];
			cmd_q.b2 <= frame_q[47:40];
			cmd_q.b3 <= frame_q[39:32];
			cmd_q.b4 <= frame_q[31:24];
			cmd_q.b5 <= frame_q[23:16];
			cmd_q.b6 <= frame_q[15:8];
			cmd_q.b7 <= frame_q[7:0];
			cmd_q.two <= (opnd == 16'd2);
		end
	end
endmodule

// ===== rtl/mbrs_back.sv =====
// Back end: register file, response byte sequencer and response CRC.
module mbrs_back #(
	parameter int REG_COUNT = mbrs_pkg::REG_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  mbrs_pkg::mbrs_cmd_t cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                out_last
);
	import mbrs_pkg::*;

	localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	// register file, cleared at reset (small, flops)
	logic [15:0] regs_q [REG_COUNT];
	logic        busy_q;
	mbrs_cmd_t   c_q;
	logic [3:0]  pos_q;
	logic [15:0] crc_q;
	logic [15:0] w0_q, w1_q;
	logic [7:0]  byte_n;
	logic [3:0]  len;
	logic [AW-1:0] a0, a1;

	assign len = c_q.is_read ? (c_q.two ? 4'd9 : 4'd7) : 4'd8;
	assign a0 = cmd.b3[AW-1:0];
	assign a1 = AW'(cmd.b3 + 8'd1);

	// response byte for the current position
	always_comb begin
		byte_n = 8'h00;
		if (!c_q.is_read) begin
			unique case (pos_q)
				4'd0: byte_n = c_q.b0;
				4'd1: byte_n = c_q.b1;
				4'd2: byte_n = c_q.b2;
				4'd3: byte_n = c_q.b3;
				4'd4: byte_n = c_q.b4;
				4'd5: byte_n = c_q.b5;
				4'd6: byte_n = c_q.b6;
				default: byte_n = c_q.b7;
			endcase
		end else if (pos_q == len - 4'd2) byte_n = crc_q[7:0];
		else if (pos_q == len - 4'd1) byte_n = crc_q[15:8];
		else begin
			unique case (pos_q)
				4'd0: byte_n = c_q.b0;
				4'd1: byte_n = FUNC_READ;
				4'd2: byte_n = c_q.two ? 8'd4 : 8'd2;
				4'd3: byte_n = w0_q[15:8];
				4'd4: byte_n = w0_q[7:0];
				4'd5: byte_n = w1_q[15:8];
				default: byte_n = w1_q[7:0];
			endcase
		end
	end

	assign cmd_ready = !busy_q;
	assign out_valid = busy_q;
	assign out_byte = byte_n;
	assign out_last = (pos_q == len - 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= 4'd0;
			for (int i = 0; i < REG_COUNT; i++) regs_q[i] <= 16'h0000;
		end else begin
			if (!busy_q && cmd_valid) begin
				busy_q <= 1'b1;
				pos_q <= 4'd0;
				if (!cmd.is_read && {cmd.b2, cmd.b3} < 16'(REG_COUNT))
					regs_q[a0] <= {cmd.b4, cmd.b5};
			end else if (busy_q && out_ready) begin
				pos_q <= pos_q + 4'd1;
				if (out_last) busy_q <= 1'b0;
			end
		end
	end

	// payload capture and running CRC over sent bytes, frozen once the CRC goes out
	always_ff @(posedge clk) begin
		if (!busy_q && cmd_valid) begin
			c_q <= cmd;
			crc_q <= CRC_INIT;
			if (cmd.is_read) begin
				w0_q <= regs_q[a0];
				w1_q <= cmd.two ? regs_q[a1] : 16'h0000;
			end
		end else if (busy_q && out_ready && pos_q < len - 4'd2) begin
			crc_q <= crc_byte(crc_q, byte_n);
		end
	end
endmodule

// ===== dv/tb.sv =====
// Testbench for the Modbus RTU holding-register slave: frame driver, response monitor and predictor.
`timescale 1ns / 100ps

module tb;
	import mbrs_pkg::*;

	localparam int NUM_REGS = 10;

	typedef struct packed {
		logic [7:0] addr;
		logic [7:0] func;
		logic [7:0] rah;
		logic [7:0] ral;
		logic [7:0] oph;
		logic [7:0] opl;
		logic [7:0] crc_a;
		logic [7:0] crc_b;
	} frame_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} resp_t;

	typedef enum int {CRC_GOOD, CRC_SWAPPED, CRC_BAD} crc_mode_t;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_valid = 0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 0;
	logic       in_valid = 0;
	logic       in_ready;
	frame_t     cur = '0;
	logic       out_valid;
	logic       out_ready = 0;
	logic [7:0] resp_byte;
	logic       resp_last;

	frame_t      frame_queue[$];
	logic [7:0]  addr_writes[$];
	resp_t       resp_expected[$];
	logic [15:0] regs_model[NUM_REGS];
	logic [7:0]  own_addr_model = 8'd1;

	int send_idle_pct = 0;
	int stall_pct = 0;
	logic want_holdoff = 0;
	logic holdoff_done = 0;
	int hold_left = 0;
	int errors = 0;
	int frames_in = 0, bytes_checked = 0, reads_ok = 0, writes_ok = 0, drops = 0;

	always #5 clk = ~clk;

	modbus_rtu_register_slave DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.frame_address(cur.addr), .frame_function(cur.func),
		.reg_addr_hi(cur.rah), .reg_addr_lo(cur.ral),
		.operand_hi(cur.oph), .operand_lo(cur.opl),
		.crc_byte_a(cur.crc_a), .crc_byte_b(cur.crc_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.resp_byte(resp_byte), .resp_last(resp_last)
	);

	// CRC-16/MODBUS over the first len bytes
	function automatic logic [15:0] modbus_crc(input logic [7:0] bytes[9], input int len);
		logic [15:0] c;
		c = 16'hFFFF;
		for (int i = 0; i < len; i++) begin
			c = c ^ {8'h00, bytes[i]};
			for (int b = 0; b < 8; b++)
				c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	// fill in the trailing CRC bytes of a frame
	function automatic frame_t seal(input frame_t f, input crc_mode_t mode);
		logic [7:0] bytes[9];
		logic [15:0] c;
		bytes = '{f.addr, f.func, f.rah, f.ral, f.oph, f.opl, 8'h00, 8'h00, 8'h00};
		c = modbus_crc(bytes, 6);
		case (mode)
			CRC_GOOD: begin
				f.crc_a = c[7:0];
				f.crc_b = c[15:8];
			end
			CRC_SWAPPED: begin
				f.crc_a = c[15:8];
				f.crc_b = c[7:0];
			end
			default: begin
				f.crc_a = c[7:0] ^ 8'($urandom_range(1, 255));
				f.crc_b = 8'($urandom);
			end
		endcase
		return f;
	endfunction

	function automatic frame_t mk(input logic [7:0] a, input logic [7:0] fn,
			input logic [15:0] ra, input logic [15:0] op, input crc_mode_t mode);
		frame_t f;
		f = {a, fn, ra, op, 16'h0000};
		return seal(f, mode);
	endfunction

	// random frame: mostly well-formed requests to this slave, some noise
	function automatic frame_t random_frame();
		int r;
		logic [7:0] a, fn;
		logic [15:0] ra, op;
		crc_mode_t mode;
		r = $urandom_range(99);
		a = (r < 88) ? own_addr_model : 8'($urandom);
		r = $urandom_range(99);
		fn = (r < 45) ? FUNC_READ : (r < 90) ? FUNC_WRITE : 8'($urandom);
		r = $urandom_range(99);
		ra = (r < 85) ? 16'($urandom_range(0, NUM_REGS + 1)) : 16'($urandom);
		if (fn == FUNC_READ) begin
			r = $urandom_range(99);
			op = (r < 85) ? 16'($urandom_range(1, 2)) :
				(r < 95) ? 16'($urandom_range(0, 3)) : 16'($urandom);
		end else
			op = 16'($urandom);
		r = $urandom_range(99);
		mode = (r < 80) ? CRC_GOOD : (r < 92) ? CRC_SWAPPED : CRC_BAD;
		if (r >= 97)
			return frame_t'({$urandom, $urandom});
		return mk(a, fn, ra, op, mode);
	endfunction

	// expected response bytes for one accepted frame; updates register model
	function automatic void predict_response(input frame_t f);
		logic [7:0] rx[9], tx[9];
		logic [15:0] c, ra, op;
		int len;
		rx = '{f.addr, f.func, f.rah, f.ral, f.oph, f.opl, f.crc_a, f.crc_b, 8'h00};
		c = modbus_crc(rx, 6);
		ra = {f.rah, f.ral};
		op = {f.oph, f.opl};
		if (f.addr != own_addr_model ||
				!((f.crc_a == c[7:0] && f.crc_b == c[15:8]) ||
				(f.crc_a == c[15:8] && f.crc_b == c[7:0]))) begin
			drops++;
			return;
		end
		if (f.func == FUNC_READ) begin
			if (op < 1 || op > 2 || 32'(ra) + 32'(op) > NUM_REGS) begin
				drops++;
				return;
			end
			tx[0] = own_addr_model;
			tx[1] = FUNC_READ;
			tx[2] = 8'(op * 2);
			len = 3;
			for (int k = 0; k < op; k++) begin
				tx[len++] = regs_model[ra + k][15:8];
				tx[len++] = regs_model[ra + k][7:0];
			end
			c = modbus_crc(tx, len);
			tx[len++] = c[7:0];
			tx[len++] = c[15:8];
			reads_ok++;
		end else if (f.func == FUNC_WRITE) begin
			if (ra < NUM_REGS)
				regs_model[ra] = op;
			tx = rx;
			len = 8;
			writes_ok++;
		end else begin
			drops++;
			return;
		end
		for (int k = 0; k < len; k++)
			resp_expected.push_back({tx[k], 1'(k == len - 1)});
	endfunction

	// frame and config driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (frame_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1;
					cur <= frame_queue.pop_front();
				end else
					in_valid <= 0;
			end
			if (!cfg_valid || cfg_ready) begin
				if (addr_writes.size() != 0) begin
					cfg_valid <= 1;
					cfg_data <= addr_writes.pop_front();
				end else
					cfg_valid <= 0;
			end
		end
	end

	// receiver back-pressure, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else if (want_holdoff && !holdoff_done) begin
			hold_left <= 300;
			holdoff_done <= 1;
			out_ready <= 0;
		end else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// monitor: predict on accepted frames, check accepted response bytes
	always @(posedge clk) begin
		resp_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				own_addr_model = cfg_data;
			if (in_valid && in_ready) begin
				frames_in++;
				predict_response(cur);
			end
			if (out_valid && out_ready) begin
				if (resp_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected byte, expected none, actual %h last %b",
						$time, resp_byte, resp_last);
				end else begin
					e = resp_expected.pop_front();
					bytes_checked++;
					if (e.data !== resp_byte || e.last !== resp_last) begin
						errors++;
						$display("%0t: mismatch, expected %h last %b, actual %h last %b",
							$time, e.data, e.last, resp_byte, resp_last);
					end
				end
			end
		end
	end

	// wait until the block is drained, then let a dropped frame finish
	task automatic wait_idle();
		do @(posedge clk);
		while (frame_queue.size() != 0 || in_valid || resp_expected.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_slave_addr(input logic [7:0] a);
		addr_writes.push_back(a);
		do @(posedge clk);
		while (addr_writes.size() != 0 || cfg_valid);
	endtask

	task automatic random_phase(input logic [7:0] a, input int n, input int idle,
			input int stall);
		set_slave_addr(a);
		send_idle_pct = idle;
		stall_pct = stall;
		// wait for the config write to land in the model before generating
		repeat (3) @(posedge clk);
		for (int i = 0; i < n; i++)
			frame_queue.push_back(random_frame());
	endtask

	// stimulus sequence
	initial begin
		foreach (regs_model[i])
			regs_model[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed frames, mostly at the reset slave address
		frame_queue.push_back(mk(8'd1, FUNC_READ, 16'd0, 16'd2, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, FUNC_WRITE, 16'd0, 16'hFFFF, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, FUNC_WRITE, 16'd9, 16'h1234, CRC_SWAPPED));
		frame_queue.push_back(mk(8'd1, FUNC_WRITE, 16'd10, 16'hBEEF, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, FUNC_WRITE, 16'hFFFF, 16'h0000, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, FUNC_READ, 16'd0, 16'd1, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, FUNC_READ, 16'd8, 16'd2, CRC_SWAPPED));
		frame_queue.push_back(mk(8'd1, FUNC_READ, 16'd9, 16'd1, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, FUNC_READ, 16'd9, 16'd2, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, FUNC_READ, 16'd0, 16'd0, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, FUNC_READ, 16'd0, 16'd3, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, FUNC_READ, 16'hFFFF, 16'd1, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, FUNC_READ, 16'd0, 16'hFFFF, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, FUNC_READ, 16'd0, 16'd2, CRC_BAD));
		frame_queue.push_back(mk(8'd2, FUNC_READ, 16'd0, 16'd2, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, 8'h00, 16'd0, 16'd1, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, 8'hFF, 16'd0, 16'd1, CRC_GOOD));
		frame_queue.push_back(frame_t'({64{1'b1}}));
		frame_queue.push_back(mk(8'd1, FUNC_WRITE, 16'd5, 16'h8001, CRC_GOOD));
		frame_queue.push_back(mk(8'd1, FUNC_READ, 16'd4, 16'd2, CRC_GOOD));
		wait_idle();

		// extreme and random addresses, idling and stall patterns
		random_phase(8'hFF, 65, 81, 0);
		wait_idle();
		want_holdoff <= 1;
		random_phase(8'h00, 65, 0, 81);
		wait_idle();
		random_phase(8'($urandom_range(2, 254)), 65, 13, 13);
		wait_idle();
		random_phase(8'h01, 65, 0, 0);
		wait_idle();

		$display("Covered %0d frames: %0d reads served, %0d writes echoed, %0d dropped;",
			frames_in, reads_ok, writes_ok, drops);
		$display("%0d response bytes checked across four slave addresses and idle mixes.",
			bytes_checked);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// run time limit
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
